FILE: rtl/core/cdca_pkg.sv
// ----------------------------------------------------------------------------
// cdca_pkg
// Shared types, widths and register codes of the decay count accumulator.
// ----------------------------------------------------------------------------
package cdca_pkg;

	localparam int ACT_W    = 32;  // activity, Q16.16
	localparam int CNT_W    = 48;  // cumulative and normalised counts, Q32.16
	localparam int SUM_W    = 40;  // beam sums
	localparam int BEAM_W   = 16;
	localparam int DECAY_W  = 16;
	localparam int GAIN_W   = 24;
	localparam int MUL_W    = 32;  // shared multiplier operand width
	localparam int PROD_W   = 2 * MUL_W;

	localparam int BIN_COUNT_BITS_DEF = 24;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_DECAY_FACTOR = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COUNT_GAIN   = 4'd1;

	localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd24109;
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd41427;

	typedef struct packed {
		logic [BEAM_W-1:0] beam_count;
		logic [BEAM_W-1:0] beam_count_gated;
		logic              counting_window;
		logic              irradiation_window;
		logic              last_bin;
	} bin_t;

	typedef struct packed {
		logic [ACT_W-1:0] activity;
		logic [CNT_W-1:0] cumulative_counts;
		logic             is_final;
		logic [CNT_W-1:0] normalized_counts;
		logic [CNT_W-1:0] normalized_counts_gated;
		logic             divide_error;
	} result_t;

endpackage

FILE: rtl/core/cdca_channels_if.sv
// ----------------------------------------------------------------------------
// cdca channel interfaces
// Valid/ready channels for bins, results and register writes.
// ----------------------------------------------------------------------------
interface cdca_bin_if;
	logic          valid;
	logic          ready;
	cdca_pkg::bin_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface cdca_res_if;
	logic              valid;
	logic              ready;
	cdca_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface cdca_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [cdca_pkg::CFG_INDEX_W-1:0]   index;
	logic [cdca_pkg::CFG_DATA_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/cdca_mul.sv
// ----------------------------------------------------------------------------
// cdca_mul
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module cdca_mul (
	input  logic                          clk,
	input  logic [cdca_pkg::MUL_W-1:0]    a,
	input  logic [cdca_pkg::MUL_W-1:0]    b,
	output logic [cdca_pkg::PROD_W-1:0]   prod
);

	logic [cdca_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= cdca_pkg::PROD_W'(a) * cdca_pkg::PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

FILE: rtl/core/cdca_div.sv
// ----------------------------------------------------------------------------
// cdca_div
// Bit-serial restoring divider, one quotient bit a cycle, 48-bit saturation.
// ----------------------------------------------------------------------------
module cdca_div #(
	parameter int NUM_W = cdca_pkg::CNT_W + cdca_pkg::BIN_COUNT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [NUM_W-1:0]             dividend,
	input  logic [cdca_pkg::SUM_W-1:0]   divisor,
	output logic                         done,
	output logic [cdca_pkg::CNT_W-1:0]   quotient
);

	localparam int STEP_W = $clog2(NUM_W);

	logic [NUM_W-1:0]           num_q;
	logic [cdca_pkg::SUM_W-1:0] den_q;
	logic [cdca_pkg::SUM_W-1:0] rem_q;
	logic [cdca_pkg::CNT_W-1:0] quot_q;
	logic                       sat_q;
	logic [STEP_W-1:0]          step_q;
	logic                       busy_q;
	logic                       done_q;

	logic [cdca_pkg::SUM_W:0]   shifted;
	logic                       ge;
	logic [cdca_pkg::SUM_W-1:0] rem_next;

	always_comb begin
		shifted  = {rem_q, num_q[NUM_W-1]};
		ge       = shifted >= {1'b0, den_q};
		rem_next = ge ? cdca_pkg::SUM_W'(shifted - {1'b0, den_q})
		              : shifted[cdca_pkg::SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= dividend;
			den_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
			sat_q  <= 1'b0;
		end else if (busy_q) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			rem_q  <= rem_next;
			quot_q <= {quot_q[cdca_pkg::CNT_W-2:0], ge};
			// a one shifted past bit 47 means the quotient no longer fits
			sat_q  <= sat_q | quot_q[cdca_pkg::CNT_W-1];
		end
	end

	assign done     = done_q;
	assign quotient = sat_q ? {cdca_pkg::CNT_W{1'b1}} : quot_q;

endmodule

FILE: rtl/core/cyclic_decay_count_accumulator_top.sv
// ----------------------------------------------------------------------------
// cyclic_decay_count_accumulator_top
// Leaky activity integrators with gated count accumulation and normalisation.
// ----------------------------------------------------------------------------
// One bin is taken per transfer on bin_ch and exactly one result transfer
// leaves on res_ch for it. An ordinary bin is handled in order: accept,
// seven multiply/accumulate steps on the one shared 32x32 multiplier, then
// result load; bin_ch.ready is high only between bins. The last bin of a
// run adds normalisation: for each stream two multiplier passes form
// counts*irradiation_bins, then the bit-serial divider forms the quotient.
// The result sits in an output register, so the next bin is accepted while
// a result still waits to be taken. Register writes on cfg are always
// accepted and must only be issued while no bin is in progress.
// ----------------------------------------------------------------------------
module cyclic_decay_count_accumulator_top #(
	parameter int BIN_COUNT_BITS = cdca_pkg::BIN_COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cdca_bin_if.sink   bin_ch,
	cdca_res_if.source res_ch,
	cdca_cfg_if.sink   cfg
);

	localparam int NUM_W  = cdca_pkg::CNT_W + BIN_COUNT_BITS;
	localparam int ACT_W  = cdca_pkg::ACT_W;
	localparam int CNT_W  = cdca_pkg::CNT_W;
	localparam int SUM_W  = cdca_pkg::SUM_W;
	localparam int MUL_W  = cdca_pkg::MUL_W;
	localparam int PROD_W = cdca_pkg::PROD_W;

	typedef enum logic [16:0] {
		ST_IDLE = 17'h00001,
		ST_KA   = 17'h00002,  // all-beam activity times decay
		ST_FA   = 17'h00004,  // all-beam feed term
		ST_KG   = 17'h00008,
		ST_FG   = 17'h00010,
		ST_CA   = 17'h00020,  // activity times gain
		ST_CG   = 17'h00040,
		ST_ACC  = 17'h00080,
		ST_NLA  = 17'h00100,  // normalisation, low half of counts
		ST_NHA  = 17'h00200,
		ST_NSA  = 17'h00400,
		ST_DVA  = 17'h00800,
		ST_NLG  = 17'h01000,
		ST_NHG  = 17'h02000,
		ST_NSG  = 17'h04000,
		ST_DVG  = 17'h08000,
		ST_OUT  = 17'h10000
	} state_t;

	state_t state_q;

	// registers
	logic [cdca_pkg::DECAY_W-1:0] decay_q;
	logic [cdca_pkg::GAIN_W-1:0]  gain_q;

	// run state
	logic [ACT_W-1:0]          act_a_q, act_g_q;
	logic [CNT_W-1:0]          counts_a_q, counts_g_q;
	logic [SUM_W-1:0]          sum_a_q, sum_g_q;
	logic [BIN_COUNT_BITS-1:0] irr_q;

	// working registers
	cdca_pkg::bin_t      bin_q;
	logic [CNT_W-1:0]    keep_q;
	logic [PROD_W-1:0]   lo_q;
	logic [CNT_W-1:0]    norm_a_q, norm_g_q;

	cdca_pkg::result_t res_q;
	logic              res_valid_q;

	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] prod;
	logic [cdca_pkg::DECAY_W:0] one_minus_d;

	logic              div_start;
	logic [NUM_W-1:0]  div_dividend;
	logic [SUM_W-1:0]  div_divisor;
	logic              div_done;
	logic [CNT_W-1:0]  div_quot;

	logic              res_load;
	logic              bin_take;

	// Round Q.32 sum to Q16.16 and clamp to 32 bits.
	function automatic logic [ACT_W-1:0] leak_round(input logic [CNT_W-1:0] keep,
	                                                input logic [PROD_W-1:0] feed);
		logic [CNT_W+1:0] s;
		logic [ACT_W+1:0] r;
		s = (CNT_W+2)'(keep) + (CNT_W+2)'({feed[32:0], 16'd0}) + (CNT_W+2)'(32768);
		r = s[CNT_W+1:16];
		return (r[ACT_W+1:ACT_W] != 2'b00) ? {ACT_W{1'b1}} : r[ACT_W-1:0];
	endfunction

	// Add the rounded count increment, saturating at 2^48-1.
	function automatic logic [CNT_W-1:0] count_add(input logic [CNT_W-1:0] acc,
	                                               input logic [PROD_W-1:0] p);
		logic [56:0]    t;
		logic [CNT_W:0] s;
		t = {1'b0, p[55:0]} + 57'd32768;
		s = (CNT_W+1)'(acc) + (CNT_W+1)'(t[56:16]);
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

	function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] acc,
	                                             input logic [cdca_pkg::BEAM_W-1:0] b);
		logic [SUM_W:0] s;
		s = (SUM_W+1)'(acc) + (SUM_W+1)'(b);
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

	assign one_minus_d = 17'h10000 - {1'b0, decay_q};

	// Steer the shared multiplier from the sequencer state.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_KA: begin
				mul_a = act_a_q;
				mul_b = MUL_W'(decay_q);
			end
			ST_FA: begin
				mul_a = MUL_W'(bin_q.beam_count);
				mul_b = MUL_W'(one_minus_d);
			end
			ST_KG: begin
				mul_a = act_g_q;
				mul_b = MUL_W'(decay_q);
			end
			ST_FG: begin
				mul_a = MUL_W'(bin_q.beam_count_gated);
				mul_b = MUL_W'(one_minus_d);
			end
			ST_CA: begin
				mul_a = act_a_q;
				mul_b = MUL_W'(gain_q);
			end
			ST_CG: begin
				mul_a = act_g_q;
				mul_b = MUL_W'(gain_q);
			end
			ST_NLA: begin
				mul_a = counts_a_q[MUL_W-1:0];
				mul_b = MUL_W'(irr_q);
			end
			ST_NHA: begin
				mul_a = MUL_W'(counts_a_q[CNT_W-1:MUL_W]);
				mul_b = MUL_W'(irr_q);
			end
			ST_NLG: begin
				mul_a = counts_g_q[MUL_W-1:0];
				mul_b = MUL_W'(irr_q);
			end
			ST_NHG: begin
				mul_a = MUL_W'(counts_g_q[CNT_W-1:MUL_W]);
				mul_b = MUL_W'(irr_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	cdca_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Full product counts*bins: low partial plus high partial shifted by 32.
	assign div_start    = (state_q == ST_NSA) || (state_q == ST_NSG);
	assign div_dividend = NUM_W'({16'd0, lo_q} + {prod[CNT_W-1:0], 32'd0});
	assign div_divisor  = (state_q == ST_NSG) ? sum_g_q : sum_a_q;

	cdca_div #(
		.NUM_W (NUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign bin_ch.ready = (state_q == ST_IDLE);
	assign bin_take     = bin_ch.valid && bin_ch.ready;
	// load the result once the output register is free or being drained
	assign res_load     = (state_q == ST_OUT) && (!res_valid_q || res_ch.ready);

	assign cfg.ready = 1'b1;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= cdca_pkg::DECAY_RESET;
			gain_q  <= cdca_pkg::GAIN_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				cdca_pkg::REG_DECAY_FACTOR: decay_q <= cfg.data[cdca_pkg::DECAY_W-1:0];
				cdca_pkg::REG_COUNT_GAIN:   gain_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (bin_take) state_q <= ST_KA;
				ST_KA:   state_q <= ST_FA;
				ST_FA:   state_q <= ST_KG;
				ST_KG:   state_q <= ST_FG;
				ST_FG:   state_q <= ST_CA;
				ST_CA:   state_q <= ST_CG;
				ST_CG:   state_q <= ST_ACC;
				ST_ACC:  state_q <= bin_q.last_bin ? ST_NLA : ST_OUT;
				ST_NLA:  state_q <= ST_NHA;
				ST_NHA:  state_q <= ST_NSA;
				ST_NSA:  state_q <= ST_DVA;
				ST_DVA:  if (div_done) state_q <= ST_NLG;
				ST_NLG:  state_q <= ST_NHG;
				ST_NHG:  state_q <= ST_NSG;
				ST_NSG:  state_q <= ST_DVG;
				ST_DVG:  if (div_done) state_q <= ST_OUT;
				ST_OUT:  if (res_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// run state: updated step by step, cleared after the final result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_a_q    <= '0;
			act_g_q    <= '0;
			counts_a_q <= '0;
			counts_g_q <= '0;
			sum_a_q    <= '0;
			sum_g_q    <= '0;
			irr_q      <= '0;
		end else begin
			case (state_q)
				ST_KG: act_a_q <= leak_round(keep_q, prod);
				ST_CA: act_g_q <= leak_round(keep_q, prod);
				ST_CG: if (bin_q.counting_window) counts_a_q <= count_add(counts_a_q, prod);
				ST_ACC: begin
					if (bin_q.counting_window) counts_g_q <= count_add(counts_g_q, prod);
					sum_a_q <= sum_add(sum_a_q, bin_q.beam_count);
					sum_g_q <= sum_add(sum_g_q, bin_q.beam_count_gated);
					if (bin_q.irradiation_window && !(&irr_q)) irr_q <= irr_q + 1'b1;
				end
				ST_OUT: if (res_load && bin_q.last_bin) begin
					act_a_q    <= '0;
					act_g_q    <= '0;
					counts_a_q <= '0;
					counts_g_q <= '0;
					sum_a_q    <= '0;
					sum_g_q    <= '0;
					irr_q      <= '0;
				end
				default: ;
			endcase
		end
	end

	// working payload: bin, partial products, quotients
	always_ff @(posedge clk) begin
		if (bin_take) bin_q <= bin_ch.data;
		if (state_q == ST_FA || state_q == ST_FG) keep_q <= prod[CNT_W-1:0];
		if (state_q == ST_NHA || state_q == ST_NHG) lo_q <= prod;
		// a zero beam sum gives zero for that stream
		if (state_q == ST_DVA && div_done) norm_a_q <= (sum_a_q == '0) ? '0 : div_quot;
		if (state_q == ST_DVG && div_done) norm_g_q <= (sum_g_q == '0) ? '0 : div_quot;
		if (res_load) begin
			res_q.activity          <= act_a_q;
			res_q.cumulative_counts <= counts_a_q;
			res_q.is_final          <= bin_q.last_bin;
			res_q.normalized_counts       <= bin_q.last_bin ? norm_a_q : '0;
			res_q.normalized_counts_gated <= bin_q.last_bin ? norm_g_q : '0;
			res_q.divide_error <= bin_q.last_bin &&
			                      (sum_a_q == '0 || sum_g_q == '0 || irr_q == '0);
		end
	end

	// output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_ch.valid = res_valid_q;
	assign res_ch.data  = res_q;

	// divider completes only while the sequencer waits on it
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DVA || state_q == ST_DVG))
		else $error("divider finished outside a wait state");

	// a pending result is never dropped by a new load
	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_ch.ready) |=> (res_valid_q && $stable(res_q)))
		else $error("pending result overwritten");

	// the final result clears the run state
	a_final_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && bin_q.last_bin) |=> (sum_a_q == '0 && irr_q == '0 && counts_g_q == '0))
		else $error("run state not cleared after final bin");

	// normalisation only follows a last bin
	a_norm_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NLA) |-> bin_q.last_bin)
		else $error("normalisation entered for an ordinary bin");

endmodule
